// File: rtl/obu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package obu_pkg;

  // Input component width and the Q1.15 result width.
  localparam int CW  = 16;
  localparam int QW  = 16;
  localparam int QBW = $clog2(QW);

  // One cell of the root chain settles one result bit.
  localparam int NB = QW;

  // Vector and component counts: a, d = (a x b) x a, c = a x b.
  localparam int NV = 3;
  localparam int NC = 9;

  // Exact widths of the intermediate vectors.
  localparam int CRW = 2 * CW + 1;        // c = a x b
  localparam int CDW = CRW + CW;          // one product of c and a
  localparam int DW  = CDW + 1;           // d = c x a, also the magnitude width
  localparam int HW  = (DW + 1) / 2;      // half of a magnitude for the square
  localparam int PW  = 4 * HW;            // sum of the partial products
  localparam int SQW = 2 * DW;            // one squared component
  localparam int SW  = SQW + 2;           // squared magnitude of a vector
  localparam int XSH = 2 * QW;            // scale of x^2 in the root test
  localparam int RW  = SW + 2 * QW + 5;   // residual and running product

  // Pipeline depths.
  localparam int FRONT_LAT = 8;
  localparam int UNIT_LAT  = NB + 2;
  localparam int LAT       = FRONT_LAT + UNIT_LAT;

  localparam logic [QW-1:0] UNIT_POS_SAT = {1'b0, {(QW-1){1'b1}}};

  typedef logic signed [CW-1:0] comp_t;

  // State that walks down the chain with one component.
  typedef struct packed {
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] p;
    logic [SW-1:0]        s;
    logic [QW-1:0]        q;
    logic                 neg;
  } cell_t;

endpackage

`default_nettype wire

// File: rtl/obu_front.sv
`timescale 1ns / 1ps
`default_nettype none

module obu_front (
  input  wire  logic                clk_i,
  input  wire  obu_pkg::comp_t      a_i [3],
  input  wire  obu_pkg::comp_t      b_i [3],
  output logic [obu_pkg::SQW-1:0]   sq_o [9],
  output logic                      neg_o [9],
  output logic [obu_pkg::SW-1:0]    s_o [3],
  output logic                      degen_o
);
  import obu_pkg::*;

  logic signed [CW-1:0]    a1_q [3];
  logic signed [2*CW-1:0]  ab1_q [6];
  logic signed [CW-1:0]    a2_q [3];
  logic signed [CRW-1:0]   c2_q [3];
  logic signed [CW-1:0]    a3_q [3];
  logic signed [CRW-1:0]   c3_q [3];
  logic signed [CDW-1:0]   ca3_q [6];
  logic                    cz3_q;
  logic signed [DW-1:0]    x4_q [NC];
  logic                    cz4_q;
  logic [DW-1:0]           mag5_q [NC];
  logic                    neg5_q [NC];
  logic                    cz5_q;
  logic [2*HW-1:0]         hh6_q [NC];
  logic [2*HW-1:0]         hl6_q [NC];
  logic [2*HW-1:0]         ll6_q [NC];
  logic                    neg6_q [NC];
  logic                    cz6_q;
  logic [SQW-1:0]          sq7_q [NC];
  logic                    neg7_q [NC];
  logic                    cz7_q;
  logic [SQW-1:0]          sq8_q [NC];
  logic                    neg8_q [NC];
  logic [SW-1:0]           s8_q [NV];
  logic                    cz8_q;

  // Products for c = a x b.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) a1_q[k] <= a_i[k];
    ab1_q[0] <= a_i[1] * b_i[2];
    ab1_q[1] <= a_i[2] * b_i[1];
    ab1_q[2] <= a_i[2] * b_i[0];
    ab1_q[3] <= a_i[0] * b_i[2];
    ab1_q[4] <= a_i[0] * b_i[1];
    ab1_q[5] <= a_i[1] * b_i[0];
  end

  // Differences give c.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      a2_q[k] <= a1_q[k];
      c2_q[k] <= CRW'(ab1_q[2*k]) - CRW'(ab1_q[2*k+1]);
    end
  end

  // Products for d = c x a, and the parallel test on c.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      a3_q[k] <= a2_q[k];
      c3_q[k] <= c2_q[k];
    end
    ca3_q[0] <= CDW'(c2_q[1]) * CDW'(a2_q[2]);
    ca3_q[1] <= CDW'(c2_q[2]) * CDW'(a2_q[1]);
    ca3_q[2] <= CDW'(c2_q[2]) * CDW'(a2_q[0]);
    ca3_q[3] <= CDW'(c2_q[0]) * CDW'(a2_q[2]);
    ca3_q[4] <= CDW'(c2_q[0]) * CDW'(a2_q[1]);
    ca3_q[5] <= CDW'(c2_q[1]) * CDW'(a2_q[0]);
    cz3_q    <= (c2_q[0] == '0) && (c2_q[1] == '0) && (c2_q[2] == '0);
  end

  // Differences give d; all nine components line up at one width.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      x4_q[k]     <= DW'(a3_q[k]);
      x4_q[3 + k] <= DW'(ca3_q[2*k]) - DW'(ca3_q[2*k+1]);
      x4_q[6 + k] <= DW'(c3_q[k]);
    end
    cz4_q <= cz3_q;
  end

  // Sign and magnitude of every component.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NC; k++) begin
      neg5_q[k] <= x4_q[k][DW-1];
      mag5_q[k] <= x4_q[k][DW-1] ? DW'(-x4_q[k]) : DW'(x4_q[k]);
    end
    cz5_q <= cz4_q;
  end

  // Squares are split into half-width partial products.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NC; k++) begin
      hh6_q[k]  <= HW'(mag5_q[k][DW-1:HW]) * HW'(mag5_q[k][DW-1:HW]);
      hl6_q[k]  <= HW'(mag5_q[k][DW-1:HW]) * mag5_q[k][HW-1:0];
      ll6_q[k]  <= mag5_q[k][HW-1:0] * mag5_q[k][HW-1:0];
      neg6_q[k] <= neg5_q[k];
    end
    cz6_q <= cz5_q;
  end

  // Partial products are summed into the square.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NC; k++) begin
      sq7_q[k]  <= SQW'((PW'(hh6_q[k]) << (2 * HW)) + (PW'(hl6_q[k]) << (HW + 1))
                        + PW'(ll6_q[k]));
      neg7_q[k] <= neg6_q[k];
    end
    cz7_q <= cz6_q;
  end

  // Squared magnitude of each vector.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NC; k++) begin
      sq8_q[k]  <= sq7_q[k];
      neg8_q[k] <= neg7_q[k];
    end
    for (int v = 0; v < NV; v++) begin
      s8_q[v] <= SW'(sq7_q[3*v]) + SW'(sq7_q[3*v+1]) + SW'(sq7_q[3*v+2]);
    end
    cz8_q <= cz7_q;
  end

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      sq_o[k]  = sq8_q[k];
      neg_o[k] = neg8_q[k];
    end
    for (int v = 0; v < NV; v++) s_o[v] = s8_q[v];
    degen_o = cz8_q;
  end

endmodule

`default_nettype wire

// File: rtl/obu_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module obu_cell (
  input  wire  logic                    clk_i,
  input  wire  logic [obu_pkg::QBW-1:0] bit_idx_i,
  input  wire  obu_pkg::cell_t          cell_i,
  output obu_pkg::cell_t                cell_o
);
  import obu_pkg::*;

  logic signed [RW-1:0] s_ext;
  logic signed [RW-1:0] r_try;
  logic                 take;
  cell_t                cell_d;
  cell_t                cell_q;

  // Trial of one result bit: the residual drops by 2^(b+2) P + 2^(2b+2) S.
  always_comb begin
    s_ext = $signed({{(RW-SW){1'b0}}, cell_i.s});
    r_try = cell_i.r - (cell_i.p <<< ({1'b0, bit_idx_i} + (QBW+1)'(2)))
                     - (s_ext <<< ({1'b0, bit_idx_i, 1'b0} + (QBW+2)'(2)));
    // Above one the magnitude may not grow.
    take  = !r_try[RW-1] &&
            ((bit_idx_i == QBW'(QW - 1)) || !cell_i.q[QW-1]);
  end

  // Keep the trial when it holds.
  always_comb begin
    cell_d = cell_i;
    if (take) begin
      cell_d.r            = r_try;
      cell_d.p            = cell_i.p + (s_ext <<< ({1'b0, bit_idx_i} + (QBW+1)'(1)));
      cell_d.q[bit_idx_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

// File: rtl/obu_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module obu_unit (
  input  wire  logic                     clk_i,
  input  wire  logic [obu_pkg::SQW-1:0]  sq_i,
  input  wire  logic                     neg_i,
  input  wire  logic [obu_pkg::SW-1:0]   s_i,
  output logic signed [obu_pkg::QW-1:0]  unit_o
);
  import obu_pkg::*;

  logic signed [RW-1:0] s_ext;
  cell_t                init_d;
  cell_t                chain [NB+1];
  logic signed [QW-1:0] res_d;
  logic signed [QW-1:0] res_q;

  // Start of the root search: residual x^2 2^32 - S, running product -S.
  always_comb begin
    s_ext      = $signed({{(RW-SW){1'b0}}, s_i});
    init_d.r   = $signed({{(RW-SQW-XSH){1'b0}}, sq_i, {XSH{1'b0}}}) - s_ext;
    init_d.p   = -s_ext;
    init_d.s   = s_i;
    init_d.q   = '0;
    init_d.neg = neg_i;
  end

  always_ff @(posedge clk_i) begin
    chain[0] <= init_d;
  end

  // One cell per result bit, most significant first.
  for (genvar i = 0; i < NB; i++) begin : g_cell
    obu_cell u_cell (
      .clk_i     (clk_i),
      .bit_idx_i (QBW'(NB - 1 - i)),
      .cell_i    (chain[i]),
      .cell_o    (chain[i+1])
    );
  end

  // Sign is applied; plus one saturates.
  always_comb begin
    if (chain[NB].neg) begin
      res_d = $signed(QW'(-chain[NB].q));
    end else if (chain[NB].q > UNIT_POS_SAT) begin
      res_d = $signed(UNIT_POS_SAT);
    end else begin
      res_d = $signed(chain[NB].q);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign unit_o = res_q;

endmodule

`default_nettype wire

// File: rtl/orthonormal_basis_unit_core.sv
// done_o comes from a strobe register chain as deep as the data path.
// Throughput: one item per cycle; busy_o stays low, so start_i is always taken.
// Latency is set by the 8-stage front end and the root units of 16 cells, one bit per cell.
// Each result shows for one cycle on done_o; the receiver cannot stall it.
// Reset clears the strobe and parallel-flag pipelines only; the data path needs no reset.
`timescale 1ns / 1ps
`default_nettype none

module orthonormal_basis_unit_core (
  input  wire  logic                        clk_i,
  input  wire  logic                        rst_ni,
  input  wire  logic                        start_i,
  output logic                              busy_o,
  input  wire  logic signed [obu_pkg::CW-1:0] a_x_i,
  input  wire  logic signed [obu_pkg::CW-1:0] a_y_i,
  input  wire  logic signed [obu_pkg::CW-1:0] a_z_i,
  input  wire  logic signed [obu_pkg::CW-1:0] b_x_i,
  input  wire  logic signed [obu_pkg::CW-1:0] b_y_i,
  input  wire  logic signed [obu_pkg::CW-1:0] b_z_i,
  output logic                              done_o,
  output logic signed [obu_pkg::QW-1:0]     u_x_o,
  output logic signed [obu_pkg::QW-1:0]     u_y_o,
  output logic signed [obu_pkg::QW-1:0]     u_z_o,
  output logic signed [obu_pkg::QW-1:0]     v_x_o,
  output logic signed [obu_pkg::QW-1:0]     v_y_o,
  output logic signed [obu_pkg::QW-1:0]     v_z_o,
  output logic signed [obu_pkg::QW-1:0]     w_x_o,
  output logic signed [obu_pkg::QW-1:0]     w_y_o,
  output logic signed [obu_pkg::QW-1:0]     w_z_o,
  output logic                              degenerate_o
);
  import obu_pkg::*;

  comp_t                a_vec [3];
  comp_t                b_vec [3];
  logic [SQW-1:0]       sq [NC];
  logic                 neg [NC];
  logic [SW-1:0]        s [NV];
  logic                 degen;
  logic signed [QW-1:0] unit [NC];
  logic [LAT-1:0]       vld_q;
  logic [LAT-1:0]       vld_d;
  logic [UNIT_LAT-1:0]  dg_q;
  logic [UNIT_LAT-1:0]  dg_d;
  logic                 deg_out;

  assign busy_o = 1'b0;

  assign a_vec[0] = a_x_i;
  assign a_vec[1] = a_y_i;
  assign a_vec[2] = a_z_i;
  assign b_vec[0] = b_x_i;
  assign b_vec[1] = b_y_i;
  assign b_vec[2] = b_z_i;

  // Cross products and squared magnitudes.
  obu_front u_front (
    .clk_i   (clk_i),
    .a_i     (a_vec),
    .b_i     (b_vec),
    .sq_o    (sq),
    .neg_o   (neg),
    .s_o     (s),
    .degen_o (degen)
  );

  // One root chain per output component.
  for (genvar k = 0; k < NC; k++) begin : g_unit
    obu_unit u_unit (
      .clk_i  (clk_i),
      .sq_i   (sq[k]),
      .neg_i  (neg[k]),
      .s_i    (s[k / 3]),
      .unit_o (unit[k])
    );
  end

  // Item strobe and parallel flag follow the data through the pipeline.
  always_comb begin
    vld_d = {vld_q[LAT-2:0], start_i & ~busy_o};
    dg_d  = {dg_q[UNIT_LAT-2:0], degen};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      dg_q  <= '0;
    end else begin
      vld_q <= vld_d;
      dg_q  <= dg_d;
    end
  end

  assign deg_out = dg_q[UNIT_LAT-1];

  // Parallel inputs give all-zero vectors.
  always_comb begin
    done_o       = vld_q[LAT-1];
    degenerate_o = deg_out;
    u_x_o = deg_out ? '0 : unit[0];
    u_y_o = deg_out ? '0 : unit[1];
    u_z_o = deg_out ? '0 : unit[2];
    v_x_o = deg_out ? '0 : unit[3];
    v_y_o = deg_out ? '0 : unit[4];
    v_z_o = deg_out ? '0 : unit[5];
    w_x_o = deg_out ? '0 : unit[6];
    w_y_o = deg_out ? '0 : unit[7];
    w_z_o = deg_out ? '0 : unit[8];
  end

`ifndef SYNTHESIS
  // A result only appears for an item taken the full latency earlier.
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result strobe without a matching item");

  // On a regular item the first vector always has a nonzero unit vector.
  a_u_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !degenerate_o) |-> ((u_x_o != '0) || (u_y_o != '0) || (u_z_o != '0)))
    else $error("unit of a is zero on a regular item");

  // The normal vector is nonzero whenever the item is regular.
  a_w_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !degenerate_o) |-> ((w_x_o != '0) || (w_y_o != '0) || (w_z_o != '0)))
    else $error("unit of a x b is zero on a regular item");
`endif

endmodule

`default_nettype wire
